FILE: src/canvas_flood_fill_rect_engine_assert.svh
// assertion macros shared by the canvas engine modules
`ifndef CANVAS_FLOOD_FILL_RECT_ENGINE_ASSERT_SVH
`define CANVAS_FLOOD_FILL_RECT_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CFF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("canvas engine check failed");

// next-cycle implication
`define CFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("canvas engine check failed");

`endif

FILE: src/cff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cff_pkg
// shared types and constants of the canvas flood fill / rectangle engine
// ----------------------------------------------------------------------------
package cff_pkg;

  localparam int COORD_W = 6;
  localparam int COLOR_W = 4;
  localparam int CMD_W   = 3;
  localparam int SIZE_W  = 7;

  localparam logic [COLOR_W-1:0] LIGHT_BLUE = 4'd9;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FILL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RECT  = 3'd4;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_RD_WAIT,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_NB,
    ST_NB_CHK,
    ST_RECT_H,
    ST_RECT_V
  } state_t;

  typedef struct packed {
    logic               start;
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] corner_x;
    logic [COORD_W-1:0] corner_y;
    logic [COLOR_W-1:0] paint_color;
  } req_t;

  typedef struct packed {
    logic               idle;
    logic               done;
    logic [COLOR_W-1:0] pixel_color;
    logic               status;
  } rsp_t;

endpackage

FILE: src/canvas_flood_fill_rect_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canvas_flood_fill_rect_engine
// palette canvas with clear, pixel access, flood fill and rectangle outline
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one command item (valid/ready), out_* returns exactly one
//   result item per command, cfg_* writes canvas_width (index 0) or
//   canvas_height (index 1); cfg_ready is always high, write only when idle
//   steps per command up to the result register load:
//     write, unknown, out-of-range : answered straight from ST_IDLE
//     read                         : via ST_RD_WAIT, registered pixel read
//     clear    : sweeps all 2^(clog2 W + clog2 H) addresses to light blue
//     fill     : done in ST_SEED if the seed has the colour, else paints and
//                pushes the seed, then per popped pixel ST_POP, ST_POP_WAIT,
//                ST_NB per neighbour and ST_NB_CHK per in-canvas one
//     rectangle: both horizontal edges, then both vertical edges, clipped
//   one item at a time: in_ready is low while a command runs or while a
//   result waits in the output register
//   reset: after rst_n the block sweeps the whole pixel memory to light blue,
//   with in_ready low; size registers go to 64
//   a stalled out_ready simply holds the result and blocks new items
// ----------------------------------------------------------------------------
module canvas_flood_fill_rect_engine #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cff_pkg::CMD_W-1:0]   in_cmd,
  input  logic [cff_pkg::COORD_W-1:0] in_pos_x,
  input  logic [cff_pkg::COORD_W-1:0] in_pos_y,
  input  logic [cff_pkg::COORD_W-1:0] in_corner_x,
  input  logic [cff_pkg::COORD_W-1:0] in_corner_y,
  input  logic [cff_pkg::COLOR_W-1:0] in_paint_color,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cff_pkg::COLOR_W-1:0] out_pixel_color,
  output logic                        out_status,
  // size registers
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [cff_pkg::SIZE_W-1:0]  cfg_data
);

  logic [cff_pkg::SIZE_W-1:0]  width_r, height_r;
  logic                        out_valid_r;
  logic [cff_pkg::COLOR_W-1:0] color_r;
  logic                        status_r;
  cff_pkg::req_t               req;
  cff_pkg::rsp_t               rsp;

  // one command in flight; the result register must be empty to take more
  assign in_ready  = rsp.idle && !out_valid_r;
  assign cfg_ready = 1'b1;

  assign req.start       = in_valid && in_ready;
  assign req.cmd         = in_cmd;
  assign req.pos_x       = in_pos_x;
  assign req.pos_y       = in_pos_y;
  assign req.corner_x    = in_corner_x;
  assign req.corner_y    = in_corner_y;
  assign req.paint_color = in_paint_color;

  // size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 7'd64;
      height_r <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == cff_pkg::REG_WIDTH) width_r <= cfg_data;
      if (cfg_index == cff_pkg::REG_HEIGHT) height_r <= cfg_data;
    end
  end

  // result register, held until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.done) begin
      color_r  <= rsp.pixel_color;
      status_r <= rsp.status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = color_r;
  assign out_status      = status_r;

  cff_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .canvas_width  (width_r),
    .canvas_height (height_r),
    .req           (req),
    .rsp           (rsp)
  );

`include "canvas_flood_fill_rect_engine_assert.svh"

  `CFF_ASSERT_SAME(a_done_slot_free, rsp.done, !out_valid_r)
  `CFF_ASSERT_NEXT(a_accept_blocks, req.start, !in_ready)
  `CFF_ASSERT_NEXT(a_done_loads, rsp.done, out_valid_r)

endmodule

FILE: src/cff_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cff_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module cff_ram #(
  parameter int DW = 4,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/cff_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cff_seq
// command sequencer around one shared coordinate / clip unit
// ----------------------------------------------------------------------------
module cff_seq #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [cff_pkg::SIZE_W-1:0] canvas_width,
  input  logic [cff_pkg::SIZE_W-1:0] canvas_height,
  input  cff_pkg::req_t              req,
  output cff_pkg::rsp_t              rsp
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int AW   = XW + YW;
  localparam int MW   = (XW > YW) ? XW : YW;
  localparam int CW   = ((MW > cff_pkg::COORD_W) ? MW : cff_pkg::COORD_W) + 1;
  localparam int CLW  = cff_pkg::COLOR_W;
  localparam int KW   = cff_pkg::COORD_W;
  localparam logic [CW:0] MAXW_C = (CW+1)'(MAX_WIDTH);
  localparam logic [CW:0] MAXH_C = (CW+1)'(MAX_HEIGHT);

  cff_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic [CLW-1:0] from_r, from_nxt, to_r, to_nxt;
  logic [AW:0]    sp_r, sp_nxt;
  logic [1:0]     nb_r, nb_nxt;
  logic [KW-1:0]  x0_r, x0_nxt, x1_r, x1_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic           side_r, side_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;

  logic [CW-1:0]  tx, ty;
  logic           nb_ok, in_box;
  logic [AW-1:0]  addr;

  logic           pix_we;
  logic [AW-1:0]  pix_waddr;
  logic [CLW-1:0] pix_wdata, pix_rdata;
  logic           stk_we;
  logic [AW-1:0]  stk_waddr, stk_raddr, stk_rdata;
  logic [AW:0]    sp_m1;

  // shared coordinate unit: picks the pixel under work and clips it
  always_comb begin
    tx    = cx_r;
    ty    = cy_r;
    nb_ok = 1'b1;
    case (state_r)
      cff_pkg::ST_IDLE: begin
        tx = CW'(req.pos_x);
        ty = CW'(req.pos_y);
      end
      cff_pkg::ST_NB, cff_pkg::ST_NB_CHK: begin
        case (nb_r)
          2'd0: tx = cx_r + 1'b1;
          2'd1: ty = cy_r + 1'b1;
          2'd2: begin
            tx    = cx_r - 1'b1;
            nb_ok = (cx_r != '0);
          end
          default: begin
            ty    = cy_r - 1'b1;
            nb_ok = (cy_r != '0);
          end
        endcase
      end
      cff_pkg::ST_RECT_H: begin
        tx = CW'(k_r);
        ty = CW'(side_r ? y1_r : y0_r);
      end
      cff_pkg::ST_RECT_V: begin
        tx = CW'(side_r ? x1_r : x0_r);
        ty = CW'(k_r);
      end
      default: ;
    endcase
    in_box = ({1'b0, tx} < (CW+1)'(canvas_width)) && ({1'b0, tx} < MAXW_C) &&
             ({1'b0, ty} < (CW+1)'(canvas_height)) && ({1'b0, ty} < MAXH_C);
    addr   = {ty[YW-1:0], tx[XW-1:0]};
  end

  assign sp_m1 = sp_r - 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cff_pkg::ST_INIT, cff_pkg::ST_CLEAR: begin
        if (clr_r == '1) state_nxt = cff_pkg::ST_IDLE;
      end
      cff_pkg::ST_IDLE: begin
        if (req.start) begin
          case (req.cmd)
            cff_pkg::CMD_CLEAR: state_nxt = cff_pkg::ST_CLEAR;
            cff_pkg::CMD_READ:  if (in_box) state_nxt = cff_pkg::ST_RD_WAIT;
            cff_pkg::CMD_FILL:  if (in_box) state_nxt = cff_pkg::ST_SEED;
            cff_pkg::CMD_RECT:  state_nxt = cff_pkg::ST_RECT_H;
            default: ;
          endcase
        end
      end
      cff_pkg::ST_RD_WAIT: state_nxt = cff_pkg::ST_IDLE;
      cff_pkg::ST_SEED: begin
        state_nxt = (pix_rdata == to_r) ? cff_pkg::ST_IDLE : cff_pkg::ST_POP;
      end
      cff_pkg::ST_POP: begin
        state_nxt = (sp_r == '0) ? cff_pkg::ST_IDLE : cff_pkg::ST_POP_WAIT;
      end
      cff_pkg::ST_POP_WAIT: state_nxt = cff_pkg::ST_NB;
      cff_pkg::ST_NB: begin
        if (nb_ok && in_box) state_nxt = cff_pkg::ST_NB_CHK;
        else if (nb_r == 2'd3) state_nxt = cff_pkg::ST_POP;
      end
      cff_pkg::ST_NB_CHK: begin
        state_nxt = (nb_r == 2'd3) ? cff_pkg::ST_POP : cff_pkg::ST_NB;
      end
      cff_pkg::ST_RECT_H: begin
        if (side_r && k_r == x1_r) state_nxt = cff_pkg::ST_RECT_V;
      end
      cff_pkg::ST_RECT_V: begin
        if (side_r && k_r == y1_r) state_nxt = cff_pkg::ST_IDLE;
      end
      default: state_nxt = cff_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    from_nxt  = from_r;
    to_nxt    = to_r;
    sp_nxt    = sp_r;
    nb_nxt    = nb_r;
    x0_nxt    = x0_r;
    x1_nxt    = x1_r;
    y0_nxt    = y0_r;
    y1_nxt    = y1_r;
    k_nxt     = k_r;
    side_nxt  = side_r;
    clr_nxt   = clr_r;
    pix_we    = 1'b0;
    pix_waddr = addr;
    pix_wdata = to_r;
    stk_we    = 1'b0;
    stk_waddr = sp_r[AW-1:0];
    stk_raddr = sp_m1[AW-1:0];
    rsp       = '0;
    rsp.idle  = (state_r == cff_pkg::ST_IDLE);
    case (state_r)
      cff_pkg::ST_INIT, cff_pkg::ST_CLEAR: begin
        pix_we    = 1'b1;
        pix_waddr = clr_r;
        pix_wdata = cff_pkg::LIGHT_BLUE;
        clr_nxt   = clr_r + 1'b1;
        rsp.done  = (state_r == cff_pkg::ST_CLEAR) && (clr_r == '1);
      end
      cff_pkg::ST_IDLE: begin
        if (req.start) begin
          to_nxt = req.paint_color;
          case (req.cmd)
            cff_pkg::CMD_CLEAR: clr_nxt = '0;
            cff_pkg::CMD_WRITE: begin
              pix_we     = in_box;
              pix_wdata  = req.paint_color;
              rsp.done   = 1'b1;
              rsp.status = !in_box;
            end
            cff_pkg::CMD_READ: begin
              rsp.done   = !in_box;
              rsp.status = !in_box;
            end
            cff_pkg::CMD_FILL: begin
              cx_nxt     = tx;
              cy_nxt     = ty;
              rsp.done   = !in_box;
              rsp.status = !in_box;
            end
            cff_pkg::CMD_RECT: begin
              x0_nxt   = (req.pos_x < req.corner_x) ? req.pos_x : req.corner_x;
              x1_nxt   = (req.pos_x < req.corner_x) ? req.corner_x : req.pos_x;
              y0_nxt   = (req.pos_y < req.corner_y) ? req.pos_y : req.corner_y;
              y1_nxt   = (req.pos_y < req.corner_y) ? req.corner_y : req.pos_y;
              k_nxt    = (req.pos_x < req.corner_x) ? req.pos_x : req.corner_x;
              side_nxt = 1'b0;
            end
            default: rsp.done = 1'b1;
          endcase
        end
      end
      cff_pkg::ST_RD_WAIT: begin
        rsp.done        = 1'b1;
        rsp.pixel_color = pix_rdata;
      end
      cff_pkg::ST_SEED: begin
        from_nxt = pix_rdata;
        if (pix_rdata == to_r) begin
          rsp.done = 1'b1;
        end else begin
          pix_we = 1'b1;
          stk_we = 1'b1;
          sp_nxt = sp_r + 1'b1;
        end
      end
      cff_pkg::ST_POP: begin
        if (sp_r == '0) rsp.done = 1'b1;
        else sp_nxt = sp_m1;
      end
      cff_pkg::ST_POP_WAIT: begin
        cx_nxt = CW'(stk_rdata[XW-1:0]);
        cy_nxt = CW'(stk_rdata[AW-1:XW]);
        nb_nxt = 2'd0;
      end
      cff_pkg::ST_NB: begin
        if (!(nb_ok && in_box)) nb_nxt = nb_r + 1'b1;
      end
      cff_pkg::ST_NB_CHK: begin
        if (pix_rdata == from_r) begin
          pix_we = 1'b1;
          stk_we = 1'b1;
          sp_nxt = sp_r + 1'b1;
        end
        nb_nxt = nb_r + 1'b1;
      end
      cff_pkg::ST_RECT_H: begin
        pix_we   = in_box;
        side_nxt = !side_r;
        if (side_r) k_nxt = (k_r == x1_r) ? y0_r : k_r + 1'b1;
      end
      cff_pkg::ST_RECT_V: begin
        pix_we   = in_box;
        side_nxt = !side_r;
        if (side_r) begin
          k_nxt    = k_r + 1'b1;
          rsp.done = (k_r == y1_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cff_pkg::ST_INIT;
      clr_r   <= '0;
      sp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      sp_r    <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    from_r <= from_nxt;
    to_r   <= to_nxt;
    nb_r   <= nb_nxt;
    x0_r   <= x0_nxt;
    x1_r   <= x1_nxt;
    y0_r   <= y0_nxt;
    y1_r   <= y1_nxt;
    k_r    <= k_nxt;
    side_r <= side_nxt;
  end

  cff_ram #(.DW(CLW), .AW(AW)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .raddr (addr),
    .rdata (pix_rdata)
  );

  cff_ram #(.DW(AW), .AW(AW)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (addr),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

`include "canvas_flood_fill_rect_engine_assert.svh"

  `CFF_ASSERT_SAME(a_idle_stack_empty, state_r == cff_pkg::ST_IDLE, sp_r == '0)
  `CFF_ASSERT_SAME(a_start_when_idle, req.start, state_r == cff_pkg::ST_IDLE)
  `CFF_ASSERT_NEXT(a_done_single, rsp.done, !rsp.done)
  `CFF_ASSERT_SAME(a_stack_bound, 1'b1, sp_r <= (AW+1)'(1 << AW))

endmodule

FILE: dv/canvas_flood_fill_rect_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canvas_flood_fill_rect_engine_checker
// watches the command, result and size channels, keeps a shadow canvas and
// compares every result item against the predicted pixel colour and status
// ----------------------------------------------------------------------------
module canvas_flood_fill_rect_engine_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [cff_pkg::CMD_W-1:0]   in_cmd,
  input  logic [cff_pkg::COORD_W-1:0] in_pos_x,
  input  logic [cff_pkg::COORD_W-1:0] in_pos_y,
  input  logic [cff_pkg::COORD_W-1:0] in_corner_x,
  input  logic [cff_pkg::COORD_W-1:0] in_corner_y,
  input  logic [cff_pkg::COLOR_W-1:0] in_paint_color,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [cff_pkg::COLOR_W-1:0] out_pixel_color,
  input  logic                        out_status,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [cff_pkg::SIZE_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending_count,
  output int                          result_count
);

  localparam int SIDE  = 64;
  localparam int CELLS = SIDE * SIDE;

  typedef struct packed {
    logic [cff_pkg::COLOR_W-1:0] pixel_color;
    logic                        status;
  } result_t;

  logic [cff_pkg::COLOR_W-1:0] canvas [CELLS];
  int unsigned                 fill_todo [$];
  int unsigned                 cols_used;
  int unsigned                 rows_used;
  result_t                     expected_q [$];

  function automatic bit on_canvas(int unsigned x, int unsigned y);
    return x < cols_used && y < rows_used;
  endfunction

  function automatic void paint_if_match(int unsigned x, int unsigned y,
                                         logic [cff_pkg::COLOR_W-1:0] from,
                                         logic [cff_pkg::COLOR_W-1:0] to);
    if (on_canvas(x, y) && canvas[y*SIDE+x] == from) begin
      canvas[y*SIDE+x] = to;
      fill_todo.push_back(y*SIDE+x);
    end
  endfunction

  // depth-first region repaint, same visiting order as the block
  function automatic void flood_region(int unsigned x, int unsigned y,
                                       logic [cff_pkg::COLOR_W-1:0] to);
    logic [cff_pkg::COLOR_W-1:0] from;
    int unsigned                 c;
    int unsigned                 cx;
    int unsigned                 cy;
    from = canvas[y*SIDE+x];
    if (from == to) return;
    fill_todo.delete();
    paint_if_match(x, y, from, to);
    while (fill_todo.size() > 0) begin
      c  = fill_todo.pop_back();
      cx = c % SIDE;
      cy = c / SIDE;
      paint_if_match(cx + 1, cy, from, to);
      paint_if_match(cx, cy + 1, from, to);
      if (cx > 0) paint_if_match(cx - 1, cy, from, to);
      if (cy > 0) paint_if_match(cx, cy - 1, from, to);
    end
  endfunction

  function automatic void plot(int unsigned x, int unsigned y,
                               logic [cff_pkg::COLOR_W-1:0] c);
    if (on_canvas(x, y)) canvas[y*SIDE+x] = c;
  endfunction

  function automatic result_t canvas_command(
    logic [cff_pkg::CMD_W-1:0] cmd, int unsigned px, int unsigned py,
    int unsigned qx, int unsigned qy, logic [cff_pkg::COLOR_W-1:0] col);
    result_t     r;
    int unsigned x0, x1, y0, y1;
    r = '0;
    case (cmd)
      cff_pkg::CMD_CLEAR: begin
        foreach (canvas[i]) canvas[i] = cff_pkg::LIGHT_BLUE;
      end
      cff_pkg::CMD_WRITE: begin
        if (on_canvas(px, py)) canvas[py*SIDE+px] = col;
        else r.status = 1'b1;
      end
      cff_pkg::CMD_READ: begin
        if (on_canvas(px, py)) r.pixel_color = canvas[py*SIDE+px];
        else r.status = 1'b1;
      end
      cff_pkg::CMD_FILL: begin
        if (on_canvas(px, py)) flood_region(px, py, col);
        else r.status = 1'b1;
      end
      cff_pkg::CMD_RECT: begin
        x0 = px < qx ? px : qx;  x1 = px < qx ? qx : px;
        y0 = py < qy ? py : qy;  y1 = py < qy ? qy : py;
        for (int unsigned k = x0; k <= x1; k++) begin
          plot(k, y0, col);
          plot(k, y1, col);
        end
        for (int unsigned k = y0; k <= y1; k++) begin
          plot(x0, k, col);
          plot(x1, k, col);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      foreach (canvas[i]) canvas[i] = cff_pkg::LIGHT_BLUE;
      cols_used = 64;
      rows_used = 64;
      expected_q.delete();
      fail_count    <= 0;
      result_count  <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cff_pkg::REG_WIDTH) cols_used = cfg_data > 64 ? 64 : cfg_data;
        else rows_used = cfg_data > 64 ? 64 : cfg_data;
      end
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        got = '{out_pixel_color, out_status};
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected: pixel_color %0d status %0d",
                 out_pixel_color, out_status);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (got.pixel_color !== want.pixel_color) begin
            $error("pixel_color expected %0d actual %0d", want.pixel_color, got.pixel_color);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(canvas_command(in_cmd, in_pos_x, in_pos_y,
                                            in_corner_x, in_corner_y, in_paint_color));
      if (errs != 0) fail_count <= fail_count + errs;
      pending_count <= expected_q.size();
    end
  end

endmodule

FILE: dv/canvas_flood_fill_rect_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canvas_flood_fill_rect_engine_tb
// drives directed and random drawing commands and size writes into the
// canvas engine; the checker beside it predicts and compares every result
// ----------------------------------------------------------------------------
module canvas_flood_fill_rect_engine_tb;

  localparam int RANDOM_ITEMS = 740;
  localparam int STALL_LIMIT  = 200000;
  // command codes with no function, expected to be ignored
  localparam logic [cff_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [cff_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [cff_pkg::CMD_W-1:0]   in_cmd;
  logic [cff_pkg::COORD_W-1:0] in_pos_x;
  logic [cff_pkg::COORD_W-1:0] in_pos_y;
  logic [cff_pkg::COORD_W-1:0] in_corner_x;
  logic [cff_pkg::COORD_W-1:0] in_corner_y;
  logic [cff_pkg::COLOR_W-1:0] in_paint_color;
  logic                        out_valid;
  logic                        out_ready;
  logic [cff_pkg::COLOR_W-1:0] out_pixel_color;
  logic                        out_status;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic                        cfg_index;
  logic [cff_pkg::SIZE_W-1:0]  cfg_data;

  int fail_count;
  int pending_count;
  int result_count;
  int items_sent;
  int idle_cycles;
  bit calm_phase;      // no idling on either side
  bit hold_receiver;   // long receiver stall for back pressure

  // clock, 8 ns period
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  canvas_flood_fill_rect_engine dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_cmd, .in_pos_x, .in_pos_y,
    .in_corner_x, .in_corner_y, .in_paint_color,
    .out_valid, .out_ready, .out_pixel_color, .out_status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  canvas_flood_fill_rect_engine_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_cmd, .in_pos_x, .in_pos_y,
    .in_corner_x, .in_corner_y, .in_paint_color,
    .out_valid, .out_ready, .out_pixel_color, .out_status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending_count, .result_count
  );

  // receiver: random stalls, none in the calm phase, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_receiver) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  initial begin
    hold_receiver = 1'b0;
    wait (items_sent >= 200);
    @(posedge clk);
    hold_receiver <= 1'b1;
    repeat (300) @(posedge clk);
    hold_receiver <= 1'b0;
  end

  // watchdog on cycles with no accepted item on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout with %0d results outstanding", pending_count);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // one command item; valid stays up until accepted
  task automatic send_cmd(logic [cff_pkg::CMD_W-1:0] cmd, int px, int py, int qx, int qy,
                          int col);
    @(posedge clk);
    while (!calm_phase && $urandom_range(99) < 11) @(posedge clk);
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_pos_x       <= px[cff_pkg::COORD_W-1:0];
    in_pos_y       <= py[cff_pkg::COORD_W-1:0];
    in_corner_x    <= qx[cff_pkg::COORD_W-1:0];
    in_corner_y    <= qy[cff_pkg::COORD_W-1:0];
    in_paint_color <= col[cff_pkg::COLOR_W-1:0];
    do @(posedge clk); while (!in_ready);
    in_valid  <= 1'b0;
    items_sent++;
  endtask

  // size write only with the engine drained
  task automatic set_size(int w, int h);
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= cff_pkg::REG_WIDTH;
    cfg_data  <= w[cff_pkg::SIZE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= cff_pkg::REG_HEIGHT;
    cfg_data  <= h[cff_pkg::SIZE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly small coordinates so fills and reads hit the canvas in use
  function automatic int pick_coord(int span);
    if ($urandom_range(9) < 7) return $urandom_range(span > 0 ? span : 0);
    return $urandom_range(63);
  endfunction

  task automatic random_cmd(int span);
    int r;
    int spare;
    logic [cff_pkg::CMD_W-1:0] cmd;
    r = $urandom_range(99);
    if      (r < 25) cmd = cff_pkg::CMD_WRITE;
    else if (r < 50) cmd = cff_pkg::CMD_READ;
    else if (r < 68) cmd = cff_pkg::CMD_FILL;
    else if (r < 88) cmd = cff_pkg::CMD_RECT;
    else if (r < 90) cmd = cff_pkg::CMD_CLEAR;
    else begin
      spare = $urandom_range(CMD_SPARE_HI, CMD_SPARE_LO);
      cmd   = spare[cff_pkg::CMD_W-1:0];
    end
    send_cmd(cmd, pick_coord(span), pick_coord(span), pick_coord(span), pick_coord(span),
             $urandom_range(15));
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = cff_pkg::CMD_CLEAR;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_corner_x    = '0;
    in_corner_y    = '0;
    in_paint_color = '0;
    cfg_valid      = 1'b0;
    cfg_index      = cff_pkg::REG_WIDTH;
    cfg_data       = '0;
    items_sent     = 0;
    calm_phase     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full canvas, field extremes, every command
    send_cmd(cff_pkg::CMD_READ, 63, 63, 0, 0, 0);
    send_cmd(cff_pkg::CMD_WRITE, 63, 63, 63, 63, 15);
    send_cmd(cff_pkg::CMD_READ, 63, 63, 0, 0, 0);
    send_cmd(cff_pkg::CMD_WRITE, 0, 0, 0, 0, 0);
    send_cmd(cff_pkg::CMD_READ, 0, 0, 0, 0, 0);
    send_cmd(cff_pkg::CMD_FILL, 5, 5, 0, 0, 9);          // seed already has the colour
    send_cmd(cff_pkg::CMD_RECT, 40, 50, 10, 20, 3);      // corners in reverse order
    send_cmd(cff_pkg::CMD_RECT, 0, 63, 63, 0, 7);
    send_cmd(cff_pkg::CMD_READ, 10, 50, 0, 0, 0);
    send_cmd(CMD_SPARE_HI, 21, 42, 42, 21, 10);          // unknown command
    send_cmd(CMD_SPARE_LO, 0, 0, 0, 0, 0);
    send_cmd(cff_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    // small canvas: clipping, outside accesses, bounded fill
    set_size(8, 6);
    send_cmd(cff_pkg::CMD_WRITE, 8, 0, 0, 0, 1);         // column outside
    send_cmd(cff_pkg::CMD_READ, 0, 6, 0, 0, 0);          // row outside
    send_cmd(cff_pkg::CMD_FILL, 9, 9, 0, 0, 2);          // seed outside
    send_cmd(cff_pkg::CMD_RECT, 2, 1, 60, 60, 4);        // clipped outline
    send_cmd(cff_pkg::CMD_FILL, 0, 0, 0, 0, 6);
    send_cmd(cff_pkg::CMD_FILL, 4, 3, 0, 0, 12);         // inside the outline
    send_cmd(cff_pkg::CMD_READ, 5, 4, 0, 0, 0);
    // single pixel canvas
    set_size(1, 1);
    send_cmd(cff_pkg::CMD_FILL, 0, 0, 0, 0, 5);
    send_cmd(cff_pkg::CMD_READ, 0, 0, 0, 0, 0);
    send_cmd(cff_pkg::CMD_READ, 1, 0, 0, 0, 0);

    // random phases over a range of sizes, calm phase in the middle
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_size(16, 12);
        1: set_size(64, 64);
        2: set_size(127, 127);   // clamps to the full canvas
        3: set_size(1, 64);
        4: set_size(0, 5);       // nothing in use
        5: set_size(64, 1);
        6: set_size($urandom_range(1, 64), $urandom_range(1, 64));
        default: set_size(24, 20);
      endcase
      calm_phase = (phase == 5);
      for (int n = 0; n < RANDOM_ITEMS / 8; n++)
        random_cmd(phase == 1 || phase == 2 ? ($urandom_range(3) == 0 ? 63 : 20) : 30);
      calm_phase = 1'b0;
    end

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d command items over several canvas sizes, checked %0d results",
             items_sent, result_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/cff_pkg.sv
src/cff_ram.sv
src/cff_seq.sv
src/canvas_flood_fill_rect_engine.sv
dv/canvas_flood_fill_rect_engine_checker.sv
dv/canvas_flood_fill_rect_engine_tb.sv
